FILE: rtl/pdls_pkg.sv
// ----------------------------------------------------------------------------
// pdls_pkg
// Types and constants shared by the PD line-follow steering block.
// ----------------------------------------------------------------------------
package pdls_pkg;

  localparam int POS_W     = 12;
  localparam int ERR_W     = 12;
  localparam int CHG_W     = 13;
  localparam int GAIN_W    = 8;
  localparam int DRV_W     = 8;
  localparam int PROD_W    = 20;
  localparam int QS_W      = PROD_W + 1;
  localparam int TERM_W    = QS_W + 1;
  localparam int CNT_W     = $clog2(PROD_W);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  localparam int ERR_MIN  = -2048;
  localparam int ERR_MAX  = 2047;
  localparam int PROD_MIN = -524288;
  localparam int PROD_MAX = 524287;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_NUM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_DEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_NUM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_DEN = 3'd5;

  typedef struct packed {
    logic accept;
    logic load_prod;
    logic div_start;
    logic div_sel_d;
    logic take_p;
    logic take_d;
    logic load_out;
  } pdls_cmd_t;

  typedef struct packed {
    logic enabled;
    logic den_zero;
    logic div_done;
    logic div_busy;
    logic out_free;
  } pdls_sts_t;

endpackage

FILE: rtl/pdls_if.sv
// ----------------------------------------------------------------------------
// pdls_if
// Valid/ready channels for position samples and wheel drive results.
// ----------------------------------------------------------------------------
interface pdls_in_if import pdls_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface

interface pdls_out_if import pdls_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DRV_W-1:0] left_drive;
  logic [DRV_W-1:0] right_drive;
  logic             halted;

  modport source (output valid, output left_drive, output right_drive, output halted,
                  input ready);
  modport sink (input valid, input left_drive, input right_drive, input halted,
                output ready);
endinterface

FILE: rtl/pd_line_follow_steering_top.sv
// ----------------------------------------------------------------------------
// pd_line_follow_steering_top
// PD steering for a differential drive: one beat of wheel drives per sample.
// A zero denominator sends an enabled sample straight to a halted result beat;
// a disabled sample is taken and gives no beat.
// The two 20-step quotients are computed in turn on the one serial divider, and
// a new sample is taken only once the last one's beat is loaded.
// Reset: synchronous active-low; sets config defaults and clears error history.
// ----------------------------------------------------------------------------
module pd_line_follow_steering_top import pdls_pkg::*; #(
  parameter int CENTER_POSITION = 2000
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pdls_in_if.sink              in_chan,
  pdls_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  pdls_cmd_t cmd;
  pdls_sts_t sts;

  pdls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdls_dp #(
    .CENTER_POSITION (CENTER_POSITION)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_position     (in_chan.position),
    .out_ready       (out_chan.ready),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_chan.valid),
    .out_left_drive  (out_chan.left_drive),
    .out_right_drive (out_chan.right_drive),
    .out_halted      (out_chan.halted)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten while holding a beat");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.halted) |->
      (out_chan.left_drive == '0 && out_chan.right_drive == '0))
    else $error("halted beat with nonzero drive");

  a_load_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> in_chan.ready)
    else $error("sequencer not back to accepting after result load");

endmodule

FILE: rtl/pdls_div.sv
// ----------------------------------------------------------------------------
// pdls_div
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module pdls_div import pdls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [GAIN_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [PROD_W-1:0] quotient
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(PROD_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [GAIN_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [GAIN_W-1:0] dvs_r;
  logic [GAIN_W:0]   rem_sh;
  logic [GAIN_W:0]   rem_diff;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[PROD_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_nxt  = ge ? rem_diff[GAIN_W-1:0] : rem_sh[GAIN_W-1:0];
    quo_nxt  = {quo_r[PROD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/pdls_dp.sv
// ----------------------------------------------------------------------------
// pdls_dp
// Datapath: gain registers, error and change, products, quotients,
// steering clamp and the output register.
// ----------------------------------------------------------------------------
module pdls_dp import pdls_pkg::*; #(
  parameter int CENTER_POSITION = 2000
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [POS_W-1:0]     in_position,
  input  logic                 out_ready,
  input  pdls_cmd_t            cmd,
  output pdls_sts_t            sts,
  output logic                 out_valid,
  output logic [DRV_W-1:0]     out_left_drive,
  output logic [DRV_W-1:0]     out_right_drive,
  output logic                 out_halted
);

  localparam int DIFF_W = $clog2(CENTER_POSITION + (1 << POS_W)) + 1;
  localparam logic signed [DIFF_W-1:0] ERR_LO = DIFF_W'(ERR_MIN);
  localparam logic signed [DIFF_W-1:0] ERR_HI = DIFF_W'(ERR_MAX);
  localparam int DPF_W = CHG_W + GAIN_W + 1;
  localparam logic signed [DPF_W-1:0] DP_LO = DPF_W'(PROD_MIN);
  localparam logic signed [DPF_W-1:0] DP_HI = DPF_W'(PROD_MAX);

  logic              enable_r;
  logic [GAIN_W-1:0] max_speed_r, prop_num_r, prop_den_r, deriv_num_r, deriv_den_r;

  logic signed [ERR_W-1:0]  prev_r, err_r;
  logic signed [CHG_W-1:0]  change_r;
  logic                     halt_r;
  logic                     psign_r;
  logic signed [PROD_W-1:0] dprod_r;
  logic signed [QS_W-1:0]   pq_r;
  logic signed [TERM_W-1:0] term_r;

  logic                     out_valid_r;
  logic [DRV_W-1:0]         left_r, right_r;
  logic                     halted_r;

  logic signed [DIFF_W-1:0]       diff_c;
  logic signed [ERR_W-1:0]        err_c;
  logic signed [CHG_W-1:0]        change_c;
  logic signed [ERR_W+GAIN_W:0]   pfull_c;
  logic signed [PROD_W-1:0]       pprod_c;
  logic signed [DPF_W-1:0]        dfull_c;
  logic signed [PROD_W-1:0]       dprod_c;
  logic [PROD_W-1:0]              pmag_c, dmag_c, dividend_c;
  logic                           div_busy, div_done;
  logic [PROD_W-1:0]              quo;
  logic signed [QS_W-1:0]         qsigned_c;
  logic                           neg_c, over_c;
  logic [TERM_W-1:0]              mag_c;
  logic [DRV_W-1:0]               red_c, left_c, right_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      max_speed_r <= '1;
      prop_num_r  <= '0;
      prop_den_r  <= '0;
      deriv_num_r <= '0;
      deriv_den_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:    enable_r    <= cfg_data[0];
        CFG_MAX_SPEED: max_speed_r <= cfg_data;
        CFG_PROP_NUM:  prop_num_r  <= cfg_data;
        CFG_PROP_DEN:  prop_den_r  <= cfg_data;
        CFG_DERIV_NUM: deriv_num_r <= cfg_data;
        CFG_DERIV_DEN: deriv_den_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    diff_c = $signed({{(DIFF_W-POS_W){1'b0}}, in_position}) -
             $signed(DIFF_W'(CENTER_POSITION));
    if (diff_c < ERR_LO) begin
      err_c = ERR_W'(ERR_MIN);
    end else if (diff_c > ERR_HI) begin
      err_c = ERR_W'(ERR_MAX);
    end else begin
      err_c = diff_c[ERR_W-1:0];
    end
    change_c = {err_c[ERR_W-1], err_c} - {prev_r[ERR_W-1], prev_r};

    pfull_c = err_r * $signed({1'b0, prop_num_r});
    pprod_c = pfull_c[PROD_W-1:0];
    pmag_c  = pprod_c[PROD_W-1] ? (~pprod_c + 1'b1) : pprod_c;

    dfull_c = change_r * $signed({1'b0, deriv_num_r});
    if (dfull_c < DP_LO) begin
      dprod_c = PROD_W'(PROD_MIN);
    end else if (dfull_c > DP_HI) begin
      dprod_c = PROD_W'(PROD_MAX);
    end else begin
      dprod_c = dfull_c[PROD_W-1:0];
    end
    dmag_c = dprod_r[PROD_W-1] ? (~dprod_r + 1'b1) : dprod_r;

    dividend_c = cmd.div_sel_d ? dmag_c : pmag_c;

    if (cmd.take_d) begin
      qsigned_c = dprod_r[PROD_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end else begin
      qsigned_c = psign_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end

    neg_c  = term_r[TERM_W-1];
    mag_c  = neg_c ? (~term_r + 1'b1) : term_r;
    over_c = mag_c > {{(TERM_W-DRV_W){1'b0}}, max_speed_r};
    red_c  = over_c ? '0 : (max_speed_r - mag_c[DRV_W-1:0]);
    left_c  = neg_c ? red_c : max_speed_r;
    right_c = neg_c ? max_speed_r : red_c;
  end

  pdls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend_c),
    .divisor  (cmd.div_sel_d ? deriv_den_r : prop_den_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.accept && enable_r && !sts.den_zero) begin
      prev_r <= err_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      err_r    <= err_c;
      change_r <= change_c;
      halt_r   <= sts.den_zero;
    end
    if (cmd.load_prod) begin
      psign_r <= pprod_c[PROD_W-1];
      dprod_r <= dprod_c;
    end
    if (cmd.take_p) begin
      pq_r <= qsigned_c;
    end
    if (cmd.take_d) begin
      term_r <= {pq_r[QS_W-1], pq_r} + {qsigned_c[QS_W-1], qsigned_c};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      left_r   <= halt_r ? '0 : left_c;
      right_r  <= halt_r ? '0 : right_c;
      halted_r <= halt_r;
    end
  end

  assign sts.enabled  = enable_r;
  assign sts.den_zero = (prop_den_r == '0) || (deriv_den_r == '0);
  assign sts.div_done = div_done;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_left_drive  = left_r;
  assign out_right_drive = right_r;
  assign out_halted      = halted_r;

endmodule

FILE: rtl/pdls_ctrl.sv
// ----------------------------------------------------------------------------
// pdls_ctrl
// Sequencer: accept; if enabled, multiply, two serial divides, load result.
// ----------------------------------------------------------------------------
module pdls_ctrl import pdls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pdls_sts_t sts,
  output pdls_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIVP = 5'b00100,
    ST_DIVD = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.enabled) begin
            state_nxt = sts.den_zero ? ST_OUT : ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.load_prod = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVP;
      end
      ST_DIVP: begin
        if (sts.div_done) begin
          cmd.take_p    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_d = 1'b1;
          state_nxt     = ST_DIVD;
        end
      end
      ST_DIVD: begin
        cmd.div_sel_d = 1'b1;
        if (sts.div_done) begin
          cmd.take_d = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives position samples into the PD steering block and checks every wheel
// drive beat against a predictor of the steering law or a fixed table value.
// Directed samples and register writes from a table come first, then random
// phases of settings and sample bursts, with random gaps on the sample side,
// a result stall pattern and one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench import pdls_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CENTER        = 2000;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 500;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REPORT_MAX    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [DRV_W-1:0] left_drive;
    logic [DRV_W-1:0] right_drive;
    logic             halted;
  } drive_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_FIXED} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    logic [POS_W-1:0]     position;
    drive_t               fixed;
  } row_t;

  localparam int DIR_ROWS = 44;
  localparam row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd2000, '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd0,    '0},
    '{ROW_CFG,    CFG_ENABLE,    8'd1,   12'd0,    '0},
    '{ROW_FIXED,  CFG_ENABLE,    8'd0,   12'd2000, '{8'd0,   8'd0,   1'b1}},
    '{ROW_FIXED,  CFG_ENABLE,    8'd0,   12'd4095, '{8'd0,   8'd0,   1'b1}},
    '{ROW_CFG,    CFG_PROP_NUM,  8'd255, 12'd0,    '0},
    '{ROW_CFG,    CFG_PROP_DEN,  8'd1,   12'd0,    '0},
    '{ROW_CFG,    CFG_DERIV_DEN, 8'd1,   12'd0,    '0},
    '{ROW_FIXED,  CFG_ENABLE,    8'd0,   12'd0,    '{8'd0,   8'd255, 1'b0}},
    '{ROW_FIXED,  CFG_ENABLE,    8'd0,   12'd4095, '{8'd255, 8'd0,   1'b0}},
    '{ROW_FIXED,  CFG_ENABLE,    8'd0,   12'd2000, '{8'd255, 8'd255, 1'b0}},
    '{ROW_CFG,    CFG_UNUSED,    8'd0,   12'd0,    '0},
    '{ROW_FIXED,  CFG_ENABLE,    8'd0,   12'd4000, '{8'd255, 8'd0,   1'b0}},
    '{ROW_CFG,    CFG_MAX_SPEED, 8'd0,   12'd0,    '0},
    '{ROW_FIXED,  CFG_ENABLE,    8'd0,   12'd1000, '{8'd0,   8'd0,   1'b0}},
    '{ROW_FIXED,  CFG_ENABLE,    8'd0,   12'd3000, '{8'd0,   8'd0,   1'b0}},
    '{ROW_CFG,    CFG_MAX_SPEED, 8'd200, 12'd0,    '0},
    '{ROW_CFG,    CFG_PROP_NUM,  8'd1,   12'd0,    '0},
    '{ROW_CFG,    CFG_PROP_DEN,  8'd3,   12'd0,    '0},
    '{ROW_CFG,    CFG_DERIV_NUM, 8'd255, 12'd0,    '0},
    '{ROW_CFG,    CFG_DERIV_DEN, 8'd255, 12'd0,    '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd1999, '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd2001, '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd1998, '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd2002, '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd0,    '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd4095, '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd4095, '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd2000, '0},
    '{ROW_CFG,    CFG_DERIV_DEN, 8'd0,   12'd0,    '0},
    '{ROW_FIXED,  CFG_ENABLE,    8'd0,   12'd100,  '{8'd0,   8'd0,   1'b1}},
    '{ROW_CFG,    CFG_DERIV_DEN, 8'd255, 12'd0,    '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd2002, '0},
    '{ROW_CFG,    CFG_PROP_DEN,  8'd0,   12'd0,    '0},
    '{ROW_FIXED,  CFG_ENABLE,    8'd0,   12'd3000, '{8'd0,   8'd0,   1'b1}},
    '{ROW_CFG,    CFG_PROP_DEN,  8'd255, 12'd0,    '0},
    '{ROW_CFG,    CFG_PROP_NUM,  8'd255, 12'd0,    '0},
    '{ROW_CFG,    CFG_DERIV_NUM, 8'd0,   12'd0,    '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd0,    '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd4095, '0},
    '{ROW_CFG,    CFG_ENABLE,    8'd0,   12'd0,    '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd4095, '0},
    '{ROW_CFG,    CFG_ENABLE,    8'd1,   12'd0,    '0},
    '{ROW_SAMPLE, CFG_ENABLE,    8'd0,   12'd2047, '0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  pdls_in_if  in_chan ();
  pdls_out_if out_chan ();

  pd_line_follow_steering_top #(.CENTER_POSITION(CENTER)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic                    m_enable    = 1'b0;
  logic [GAIN_W-1:0]       m_max_speed = 8'd255;
  logic [GAIN_W-1:0]       m_prop_num  = '0;
  logic [GAIN_W-1:0]       m_prop_den  = '0;
  logic [GAIN_W-1:0]       m_deriv_num = '0;
  logic [GAIN_W-1:0]       m_deriv_den = '0;
  logic signed [ERR_W-1:0] m_prev_err  = '0;

  drive_t pending_drives [$];
  int     mismatches    = 0;
  int     enabled_beats = 0;
  int     cycle_count   = 0;
  bit     hold_go       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic drive_t steer_drives(logic [POS_W-1:0] pos);
    int     err, chg, pp, dp, term, ms;
    drive_t d;
    if (m_prop_den == 0 || m_deriv_den == 0) begin
      return '{left_drive: '0, right_drive: '0, halted: 1'b1};
    end
    err = clamp(int'(pos) - CENTER, ERR_MIN, ERR_MAX);
    chg = err - int'(m_prev_err);
    m_prev_err = ERR_W'(err);
    pp = clamp(err * int'(m_prop_num), PROD_MIN, PROD_MAX);
    dp = clamp(chg * int'(m_deriv_num), PROD_MIN, PROD_MAX);
    term = pp / int'(m_prop_den) + dp / int'(m_deriv_den);
    ms = int'(m_max_speed);
    term = clamp(term, -ms, ms);
    d.halted = 1'b0;
    if (term < 0) begin
      d.left_drive  = DRV_W'(ms + term);
      d.right_drive = DRV_W'(ms);
    end else begin
      d.left_drive  = DRV_W'(ms);
      d.right_drive = DRV_W'(ms - term);
    end
    return d;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(bit nonzero);
    case ($urandom_range(0, 5))
      0:       return 8'd255;
      1:       return nonzero ? 8'd1 : 8'd0;
      2, 3:    return GAIN_W'($urandom_range(nonzero ? 1 : 0, 16));
      default: return GAIN_W'($urandom_range(nonzero ? 1 : 0, 255));
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return POS_W'(CENTER - 64 + int'($urandom_range(0, 128)));
      4, 5, 6, 7: return POS_W'($urandom_range(0, 4000));
      8:          return POS_W'($urandom_range(4001, 4095));
      default: begin
        case ($urandom_range(0, 3))
          0:       return 12'd0;
          1:       return 12'd4095;
          2:       return 12'd4000;
          default: return POS_W'(CENTER);
        endcase
      end
    endcase
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_ENABLE:    m_enable    = val[0];
      CFG_MAX_SPEED: m_max_speed = val;
      CFG_PROP_NUM:  m_prop_num  = val;
      CFG_PROP_DEN:  m_prop_den  = val;
      CFG_DERIV_NUM: m_deriv_num = val;
      CFG_DERIV_DEN: m_deriv_den = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold valid high across back-to-back beats; the caller lowers it
  task automatic send_sample(logic [POS_W-1:0] pos, bit use_fixed, drive_t fixed);
    drive_t d;
    in_chan.valid    <= 1'b1;
    in_chan.position <= pos;
    do @(posedge clk); while (!in_chan.ready);
    if (m_enable) begin
      d = steer_drives(pos);
      if (use_fixed) d = fixed;
      pending_drives.push_back(d);
      enabled_beats++;
    end
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what, drive_t exp, drive_t act);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%s: expected L=%0d R=%0d H=%0d, got L=%0d R=%0d H=%0d", what,
               exp.left_drive, exp.right_drive, exp.halted,
               act.left_drive, act.right_drive, act.halted);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    drive_t act, exp;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      act = '{out_chan.left_drive, out_chan.right_drive, out_chan.halted};
      if (pending_drives.size() == 0) begin
        flag_mismatch("beat with nothing pending", '0, act);
      end else begin
        exp = pending_drives.pop_front();
        if (act.left_drive !== exp.left_drive || act.right_drive !== exp.right_drive ||
            act.halted !== exp.halted)
          flag_mismatch("drive mismatch", exp, act);
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    out_chan.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b1;
        repeat (80) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned       kind, items, burst, gap;
    logic [GAIN_W-1:0] ms, pn, pd, dn, dd;
    bit                first;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_ENABLE;
    cfg_data         <= '0;
    in_chan.valid    <= 1'b0;
    in_chan.position <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(DIRECTED[i].index, DIRECTED[i].data);
      end else begin
        send_sample(DIRECTED[i].position, DIRECTED[i].kind == ROW_FIXED, DIRECTED[i].fixed);
      end
    end

    enabled_beats = 0;
    first = 1'b1;
    while (enabled_beats < RANDOM_ITEMS) begin
      kind = first ? 2 : $urandom_range(0, 9);
      ms = pick_gain(1'b0);
      pn = pick_gain(1'b0);
      dn = pick_gain(1'b0);
      pd = pick_gain(1'b1);
      dd = pick_gain(1'b1);
      if (kind == 1) begin
        if ($urandom_range(0, 1)) pd = '0;
        else dd = '0;
      end
      wait_idle();
      cfg_write(CFG_ENABLE, (kind != 0) ? 8'd1 : 8'd0);
      cfg_write(CFG_MAX_SPEED, ms);
      cfg_write(CFG_PROP_NUM, pn);
      cfg_write(CFG_PROP_DEN, pd);
      cfg_write(CFG_DERIV_NUM, dn);
      cfg_write(CFG_DERIV_DEN, dd);
      items = first ? 200 : (kind == 0) ? 15 : $urandom_range(30, 110);
      hold_go = first;
      first = 1'b0;
      while (items > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > items) burst = items;
        items -= burst;
        repeat (burst) send_sample(pick_position(), 1'b0, '0);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        if (gap > 0) begin
          in_chan.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pdls_pkg.sv
rtl/pdls_if.sv
rtl/pdls_div.sv
rtl/pdls_dp.sv
rtl/pdls_ctrl.sv
rtl/pd_line_follow_steering_top.sv
sim/testbench.sv
